/* hdl/hdga_pkg.sv */
package hdga_pkg;

  // Field and datapath widths
  localparam int COORD_BITS   = 16;
  localparam int FRAC_BITS    = 8;
  localparam int HEAD_BITS    = 8 + FRAC_BITS;
  localparam int ANGLE_BITS   = 32;
  localparam int SCALE_BITS   = 40;
  localparam int CORDIC_STEPS = 32;
  localparam int STEP_BITS    = $clog2(CORDIC_STEPS);
  localparam int DIFF_BITS    = COORD_BITS + 1;
  localparam int VEC_BITS     = DIFF_BITS + 1;
  localparam int WORK_BITS    = SCALE_BITS + 3;
  localparam int SHIFT_BITS   = $clog2(SCALE_BITS + 1);
  localparam int ROUND_SHIFT  = ANGLE_BITS - HEAD_BITS;
  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_BITS    = $clog2(QUEUE_DEPTH);

  // Quarter-turn codes: starting angle of the accumulator, or the fixed answer
  localparam logic [1:0] QUAD_EAST  = 2'd0;
  localparam logic [1:0] QUAD_NORTH = 2'd1;
  localparam logic [1:0] QUAD_WEST  = 2'd2;
  localparam logic [1:0] QUAD_SOUTH = 2'd3;

  // Normalized vector handed from the front end to the CORDIC pipe
  typedef struct packed {
    logic signed [WORK_BITS-1:0] x;
    logic signed [WORK_BITS-1:0] y;
    logic                        spec;
    logic [1:0]                  quad;
  } vec_t;

  // atan(2^-i) as a fraction of a turn, 2^32 per turn
  function automatic logic [ANGLE_BITS-1:0] atan_turn(input logic [STEP_BITS-1:0] idx);
    logic [ANGLE_BITS-1:0] val;
    case (idx)
      5'd0:    val = 32'h20000000;
      5'd1:    val = 32'h12E4051E;
      5'd2:    val = 32'h09FB385B;
      5'd3:    val = 32'h051111D4;
      5'd4:    val = 32'h028B0D43;
      5'd5:    val = 32'h0145D7E1;
      5'd6:    val = 32'h00A2F61E;
      5'd7:    val = 32'h00517C55;
      5'd8:    val = 32'h0028BE53;
      5'd9:    val = 32'h00145F2F;
      5'd10:   val = 32'h000A2F98;
      5'd11:   val = 32'h000517CC;
      5'd12:   val = 32'h00028BE6;
      5'd13:   val = 32'h000145F3;
      5'd14:   val = 32'h0000A2FA;
      5'd15:   val = 32'h0000517D;
      5'd16:   val = 32'h000028BE;
      5'd17:   val = 32'h0000145F;
      5'd18:   val = 32'h00000A30;
      5'd19:   val = 32'h00000518;
      5'd20:   val = 32'h0000028C;
      5'd21:   val = 32'h00000146;
      5'd22:   val = 32'h000000A3;
      5'd23:   val = 32'h00000051;
      5'd24:   val = 32'h00000029;
      5'd25:   val = 32'h00000014;
      5'd26:   val = 32'h0000000A;
      5'd27:   val = 32'h00000005;
      5'd28:   val = 32'h00000003;
      5'd29:   val = 32'h00000001;
      5'd30:   val = 32'h00000001;
      default: val = 32'h00000000;
    endcase
    return val;
  endfunction

endpackage

/* hdl/hdga_front.sv */
module hdga_front (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  src_valid,
  output logic                                  src_stall,
  input  logic signed [hdga_pkg::COORD_BITS-1:0] from_x,
  input  logic signed [hdga_pkg::COORD_BITS-1:0] from_y,
  input  logic signed [hdga_pkg::COORD_BITS-1:0] to_x,
  input  logic signed [hdga_pkg::COORD_BITS-1:0] to_y,
  output logic                                  ent_valid,
  output hdga_pkg::vec_t                        ent,
  input  logic                                  ent_ready
);
  import hdga_pkg::*;

  logic v1, v2, v3;
  logic f1_rdy, f2_rdy, f3_rdy;

  logic signed [DIFF_BITS-1:0] dx, dy, dx_next, dy_next;
  logic signed [VEC_BITS-1:0]  vx, vy, vx_next, vy_next;
  logic signed [VEC_BITS-1:0]  ext_dx, ext_dy, abs_y;
  logic [DIFF_BITS-1:0]        mag_or;
  logic [SHIFT_BITS-1:0]       len;
  logic [SHIFT_BITS-1:0]       sh, sh_next;
  logic                        spec, spec_next;
  logic [1:0]                  quad, quad_next;
  logic                        dx_zero, dy_zero, dx_neg, dy_pos;
  logic signed [WORK_BITS-1:0] wide_x, wide_y;
  vec_t                        ent_next;

  // Backpressure through the three front stages
  assign f3_rdy    = !v3 || ent_ready;
  assign f2_rdy    = !v2 || f3_rdy;
  assign f1_rdy    = !v1 || f2_rdy;
  assign src_stall = !f1_rdy;
  assign ent_valid = v3;

  // Stage 1: coordinate differences
  assign dx_next = $signed({to_x[COORD_BITS-1], to_x}) - $signed({from_x[COORD_BITS-1], from_x});
  assign dy_next = $signed({to_y[COORD_BITS-1], to_y}) - $signed({from_y[COORD_BITS-1], from_y});

  // Stage 2: classify, fold into the right half plane, find magnitude length
  always_comb begin
    dx_zero = (dx == '0);
    dy_zero = (dy == '0);
    dx_neg  = dx[DIFF_BITS-1];
    dy_pos  = !dy[DIFF_BITS-1] && !dy_zero;
    spec_next = dx_zero || dy_zero;
    if (dx_zero) begin
      quad_next = dy_pos ? QUAD_SOUTH : QUAD_NORTH;
    end else begin
      quad_next = dx_neg ? QUAD_WEST : QUAD_EAST;
    end
    ext_dx  = $signed({dx[DIFF_BITS-1], dx});
    ext_dy  = $signed({dy[DIFF_BITS-1], dy});
    vx_next = dx_neg ? -ext_dx : ext_dx;
    vy_next = dx_neg ? ext_dy : -ext_dy;
    abs_y   = vy_next[VEC_BITS-1] ? -vy_next : vy_next;
    // bit length of max(|x|,|y|) equals bit length of their OR
    mag_or  = vx_next[DIFF_BITS-1:0] | abs_y[DIFF_BITS-1:0];
    len     = '0;
    for (int b = 0; b < DIFF_BITS; b++) begin
      if (mag_or[b]) len = SHIFT_BITS'(b + 1);
    end
    sh_next = SHIFT_BITS'(SCALE_BITS) - len;
  end

  // Stage 3: scale so the larger component has SCALE_BITS bits
  always_comb begin
    wide_x = $signed({{(WORK_BITS-VEC_BITS){vx[VEC_BITS-1]}}, vx});
    wide_y = $signed({{(WORK_BITS-VEC_BITS){vy[VEC_BITS-1]}}, vy});
    ent_next.x    = wide_x <<< sh;
    ent_next.y    = wide_y <<< sh;
    ent_next.spec = spec;
    ent_next.quad = quad;
  end

  // Stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (f1_rdy) v1 <= src_valid;
      if (f2_rdy) v2 <= v1;
      if (f3_rdy) v3 <= v2;
    end
  end

  // Stage payloads
  always_ff @(posedge clk) begin
    if (f1_rdy) begin
      dx <= dx_next;
      dy <= dy_next;
    end
    if (f2_rdy) begin
      vx   <= vx_next;
      vy   <= vy_next;
      sh   <= sh_next;
      spec <= spec_next;
      quad <= quad_next;
    end
    if (f3_rdy) begin
      ent <= ent_next;
    end
  end

endmodule

/* hdl/hdga_queue.sv */
module hdga_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  hdga_pkg::vec_t push_data,
  output logic           pop_valid,
  input  logic           pop_ready,
  output hdga_pkg::vec_t pop_data
);
  import hdga_pkg::*;

  vec_t                 mem [0:QUEUE_DEPTH-1];
  logic [QPTR_BITS-1:0] wr_ptr, rd_ptr;
  logic [QPTR_BITS:0]   count;
  logic                 push, pop;

  assign push_ready = (count != (QPTR_BITS+1)'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = mem[rd_ptr];

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

endmodule

/* hdl/hdga_cordic.sv */
module hdga_cordic (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              ent_valid,
  input  hdga_pkg::vec_t                    ent,
  output logic                              ent_ready,
  output logic                              res_valid,
  input  logic                              res_stall,
  output logic [hdga_pkg::HEAD_BITS-1:0]    heading
);
  import hdga_pkg::*;

  localparam logic [ANGLE_BITS-1:0] HALF_LSB = ANGLE_BITS'(1) << (ROUND_SHIFT - 1);

  logic                        en;
  logic [CORDIC_STEPS:0]       sv;
  logic signed [WORK_BITS-1:0] sx   [0:CORDIC_STEPS];
  logic signed [WORK_BITS-1:0] sy   [0:CORDIC_STEPS];
  logic [ANGLE_BITS-1:0]       sz   [0:CORDIC_STEPS];
  logic                        sspec[0:CORDIC_STEPS];
  logic [1:0]                  squad[0:CORDIC_STEPS];
  logic [ANGLE_BITS-1:0]       rounded;
  logic [HEAD_BITS-1:0]        heading_next;

  // Whole pipe freezes only while a finished result waits
  assign en        = !(res_valid && res_stall);
  assign ent_ready = en;

  // Valid bits and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      sv        <= '0;
      res_valid <= 1'b0;
    end else if (en) begin
      sv        <= {sv[CORDIC_STEPS-1:0], ent_valid};
      res_valid <= sv[CORDIC_STEPS];
    end
  end

  // Entry stage: accumulator starts at the folded quarter
  always_ff @(posedge clk) begin
    if (en) begin
      sx[0]    <= ent.x;
      sy[0]    <= ent.y;
      sz[0]    <= {ent.quad, {(ANGLE_BITS-2){1'b0}}};
      sspec[0] <= ent.spec;
      squad[0] <= ent.quad;
    end
  end

  // One rotation per stage, shifts round toward minus infinity
  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
    logic signed [WORK_BITS-1:0] xs, ys;
    logic [ANGLE_BITS-1:0]       at;
    logic                        up;

    assign xs = sx[k] >>> k;
    assign ys = sy[k] >>> k;
    assign at = atan_turn(STEP_BITS'(k));
    assign up = (sy[k] > 0);

    always_ff @(posedge clk) begin
      if (en) begin
        sx[k+1]    <= up ? sx[k] + ys : sx[k] - ys;
        sy[k+1]    <= up ? sy[k] - xs : sy[k] + xs;
        sz[k+1]    <= up ? sz[k] + at : sz[k] - at;
        sspec[k+1] <= sspec[k];
        squad[k+1] <= squad[k];
      end
    end
  end

  // Round half up to the output grid; axis-aligned cases are exact quarters
  always_comb begin
    rounded = sz[CORDIC_STEPS] + HALF_LSB;
    if (sspec[CORDIC_STEPS]) begin
      heading_next = {squad[CORDIC_STEPS], {(HEAD_BITS-2){1'b0}}};
    end else begin
      heading_next = rounded[ANGLE_BITS-1:ROUND_SHIFT];
    end
  end

  always_ff @(posedge clk) begin
    if (en) heading <= heading_next;
  end

endmodule

/* hdl/heading_angle_256.sv */
// Throughput: one query per cycle while query_stall is low.
// Pipeline: 3 front stages, 4-entry queue, 33-stage CORDIC, output register.
// The CORDIC pipe holds only while the output register carries an untaken result; the front
// keeps filling the queue meanwhile.
// Reset (synchronous, active high) clears all valid bits and the queue; no clearing pass.
module heading_angle_256 (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  query_valid,
  output logic                                  query_stall,
  input  logic signed [hdga_pkg::COORD_BITS-1:0] from_x,
  input  logic signed [hdga_pkg::COORD_BITS-1:0] from_y,
  input  logic signed [hdga_pkg::COORD_BITS-1:0] to_x,
  input  logic signed [hdga_pkg::COORD_BITS-1:0] to_y,
  output logic                                  result_valid,
  input  logic                                  result_stall,
  output logic [hdga_pkg::HEAD_BITS-1:0]        heading
);
  import hdga_pkg::*;

  logic f_valid, f_ready;
  vec_t f_ent;
  logic q_valid, q_ready;
  vec_t q_ent;

  // Front end: differences, classification, normalization
  hdga_front u_front (
    .clk       (clk),
    .rst       (rst),
    .src_valid (query_valid),
    .src_stall (query_stall),
    .from_x    (from_x),
    .from_y    (from_y),
    .to_x      (to_x),
    .to_y      (to_y),
    .ent_valid (f_valid),
    .ent       (f_ent),
    .ent_ready (f_ready)
  );

  // Decoupling queue
  hdga_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_ent),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_ent)
  );

  // Back end: pipelined CORDIC and output register
  hdga_cordic u_cordic (
    .clk       (clk),
    .rst       (rst),
    .ent_valid (q_valid),
    .ent       (q_ent),
    .ent_ready (q_ready),
    .res_valid (result_valid),
    .res_stall (result_stall),
    .heading   (heading)
  );

endmodule

/* tb/sv/heading_angle_256_tb.sv */
module heading_angle_256_tb;
  import hdga_pkg::*;

  // Fixed headings as fractions of a turn, 2^32 per turn
  localparam logic [ANGLE_BITS-1:0] TURN_ZERO          = 32'h00000000;
  localparam logic [ANGLE_BITS-1:0] TURN_QUARTER       = 32'h40000000;
  localparam logic [ANGLE_BITS-1:0] TURN_HALF          = 32'h80000000;
  localparam logic [ANGLE_BITS-1:0] TURN_THREE_QUARTER = 32'hC0000000;
  localparam logic [ANGLE_BITS:0]   HALF_LSB           = 33'd1 << (ROUND_SHIFT - 1);

  // atan(2^-i) in turns, entry 0 in the low word
  localparam logic [CORDIC_STEPS-1:0][ANGLE_BITS-1:0] ATAN_TABLE = {
    32'h00000000, 32'h00000001, 32'h00000001, 32'h00000003,
    32'h00000005, 32'h0000000A, 32'h00000014, 32'h00000029,
    32'h00000051, 32'h000000A3, 32'h00000146, 32'h0000028C,
    32'h00000518, 32'h00000A30, 32'h0000145F, 32'h000028BE,
    32'h0000517D, 32'h0000A2FA, 32'h000145F3, 32'h00028BE6,
    32'h000517CC, 32'h000A2F98, 32'h00145F2F, 32'h0028BE53,
    32'h00517C55, 32'h00A2F61E, 32'h0145D7E1, 32'h028B0D43,
    32'h051111D4, 32'h09FB385B, 32'h12E4051E, 32'h20000000
  };

  localparam int CYCLE_LIMIT = 500000;
  localparam int HOLD_AFTER  = 700;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_WAIT  = 48;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_t;

  typedef struct {
    logic signed [COORD_BITS-1:0] fx;
    logic signed [COORD_BITS-1:0] fy;
    logic signed [COORD_BITS-1:0] tx;
    logic signed [COORD_BITS-1:0] ty;
  } point_pair_t;

  typedef struct {
    point_pair_t           pair;
    logic [HEAD_BITS-1:0]  heading;
  } heading_due_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic query_valid = 1'b0;
  logic query_stall;
  logic signed [COORD_BITS-1:0] from_x = '0;
  logic signed [COORD_BITS-1:0] from_y = '0;
  logic signed [COORD_BITS-1:0] to_x = '0;
  logic signed [COORD_BITS-1:0] to_y = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  logic [HEAD_BITS-1:0] heading;

  point_pair_t  pair_queue[$];
  heading_due_t heading_due[$];
  point_pair_t  next_pair;
  heading_due_t oldest_due;

  logic query_taken = 1'b0;
  logic bench_idle = 1'b0;
  int   queries_taken = 0;
  int   mismatch_count = 0;
  int   cycle_count = 0;
  int   burst_left = 1;
  int   gap_left = 0;
  int   hold_left = 0;
  logic hold_armed = 1'b1;
  stall_mode_t stall_mode = STALL_NONE;
  int   mode_left = 0;
  int   stall_phase = 0;

  heading_angle_256 dut (
    .clk          (clk),
    .rst          (rst),
    .query_valid  (query_valid),
    .query_stall  (query_stall),
    .from_x       (from_x),
    .from_y       (from_y),
    .to_x         (to_x),
    .to_y         (to_y),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .heading      (heading)
  );

  always #6 clk = ~clk;

  // Heading predictor: vectoring CORDIC on exact integers
  function automatic logic [HEAD_BITS-1:0] predict_heading(input point_pair_t p);
    longint dx, dy, vx, vy, mag, sx, sy;
    logic [ANGLE_BITS-1:0] acc;
    logic [ANGLE_BITS:0]   rounded;
    int nbits;
    dx  = longint'(p.tx) - longint'(p.fx);
    dy  = longint'(p.ty) - longint'(p.fy);
    acc = TURN_ZERO;
    if (dx == 0) begin
      acc = (dy <= 0) ? TURN_QUARTER : TURN_THREE_QUARTER;
    end else if (dy == 0) begin
      acc = (dx > 0) ? TURN_ZERO : TURN_HALF;
    end else begin
      vx = dx;
      vy = -dy;
      // left half plane: rotate by half a turn first
      if (vx < 0) begin
        vx  = -vx;
        vy  = -vy;
        acc = TURN_HALF;
      end
      // normalize so the larger component has SCALE_BITS bits
      mag = (vy < 0) ? -vy : vy;
      if (vx > mag) mag = vx;
      nbits = 0;
      while (mag != 0) begin
        mag = mag >> 1;
        nbits++;
      end
      if (nbits < SCALE_BITS) begin
        vx = vx <<< (SCALE_BITS - nbits);
        vy = vy <<< (SCALE_BITS - nbits);
      end
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        sx = vx >>> i;
        sy = vy >>> i;
        if (vy > 0) begin
          vx  = vx + sy;
          vy  = vy - sx;
          acc = acc + ATAN_TABLE[i];
        end else begin
          vx  = vx - sy;
          vy  = vy + sx;
          acc = acc - ATAN_TABLE[i];
        end
      end
    end
    // round half up, full turn wraps to zero
    rounded = {1'b0, acc} + HALF_LSB;
    return rounded[ROUND_SHIFT +: HEAD_BITS];
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch @%0d: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  task automatic add_pair(input int fx, input int fy, input int tx, input int ty);
    point_pair_t p;
    p.fx = fx[COORD_BITS-1:0];
    p.fy = fy[COORD_BITS-1:0];
    p.tx = tx[COORD_BITS-1:0];
    p.ty = ty[COORD_BITS-1:0];
    pair_queue.push_back(p);
  endtask

  function automatic int rand_coord();
    logic signed [COORD_BITS-1:0] v;
    v = COORD_BITS'($urandom);
    return int'(v);
  endfunction

  function automatic int corner_coord();
    int pick;
    pick = $urandom_range(0, 6);
    case (pick)
      0:       return -32768;
      1:       return -32767;
      2:       return -1;
      3:       return 0;
      4:       return 1;
      5:       return 32766;
      default: return 32767;
    endcase
  endfunction

  // Random pairs: full range, short and medium vectors, axis-aligned, corner values
  task automatic add_random_pairs(input int count);
    int fx, fy, kind;
    for (int n = 0; n < count; n++) begin
      fx   = rand_coord();
      fy   = rand_coord();
      kind = $urandom_range(0, 19);
      if (kind < 8) begin
        add_pair(fx, fy, rand_coord(), rand_coord());
      end else if (kind < 12) begin
        add_pair(fx, fy, fx + $urandom_range(0, 8) - 4, fy + $urandom_range(0, 8) - 4);
      end else if (kind < 14) begin
        if ($urandom_range(0, 1) == 0) add_pair(fx, fy, fx, rand_coord());
        else add_pair(fx, fy, rand_coord(), fy);
      end else if (kind < 17) begin
        add_pair(corner_coord(), corner_coord(), corner_coord(), corner_coord());
      end else begin
        add_pair(fx, fy, fx + $urandom_range(0, 600) - 300, fy + $urandom_range(0, 600) - 300);
      end
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (!bench_idle) @(negedge clk);
  endtask

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[heading_angle_256] ERROR");
      $finish;
    end
  end

  // Query driver: bursts with random gaps, payload held while stalled
  always @(negedge clk) begin
    if (rst) begin
      query_valid <= 1'b0;
    end else if (!query_valid || query_taken) begin
      if (gap_left > 0) begin
        gap_left    <= gap_left - 1;
        query_valid <= 1'b0;
      end else if (pair_queue.size() > 0) begin
        next_pair   = pair_queue.pop_front();
        from_x      <= next_pair.fx;
        from_y      <= next_pair.fy;
        to_x        <= next_pair.tx;
        to_y        <= next_pair.ty;
        query_valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        query_valid <= 1'b0;
      end
    end
  end

  // Result receiver: one long hold-off, otherwise a changing stall pattern
  always @(negedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left    <= hold_left - 1;
      result_stall <= 1'b1;
    end else if (hold_armed && queries_taken >= HOLD_AFTER) begin
      hold_armed   <= 1'b0;
      hold_left    <= HOLD_CYCLES;
      result_stall <= 1'b1;
    end else begin
      stall_phase <= stall_phase + 1;
      if (mode_left == 0) begin
        stall_mode <= stall_mode_t'($urandom_range(0, 3));
        mode_left  <= $urandom_range(20, 200);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        STALL_NONE:     result_stall <= 1'b0;
        STALL_LIGHT:    result_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY:    result_stall <= ($urandom_range(0, 9) < 7);
        default:        result_stall <= ((stall_phase % 5) < 2);
      endcase
    end
  end

  // Monitor: check results against the oldest prediction, predict accepted queries
  always @(posedge clk) begin
    if (rst) begin
      query_taken <= 1'b0;
      bench_idle  <= 1'b0;
    end else begin
      query_taken <= query_valid && !query_stall;
      if (result_valid && !result_stall) begin
        if (heading_due.size() == 0) begin
          report_mismatch($sformatf("unexpected result heading=%h", heading));
        end else begin
          oldest_due = heading_due.pop_front();
          if (heading !== oldest_due.heading)
            report_mismatch($sformatf("(%0d,%0d)->(%0d,%0d) heading=%h predicted=%h",
                                      oldest_due.pair.fx, oldest_due.pair.fy,
                                      oldest_due.pair.tx, oldest_due.pair.ty,
                                      heading, oldest_due.heading));
        end
      end
      if (query_valid && !query_stall) begin
        oldest_due.pair.fx = from_x;
        oldest_due.pair.fy = from_y;
        oldest_due.pair.tx = to_x;
        oldest_due.pair.ty = to_y;
        oldest_due.heading = predict_heading(oldest_due.pair);
        heading_due.push_back(oldest_due);
        queries_taken <= queries_taken + 1;
      end
      bench_idle <= (pair_queue.size() == 0) && !query_valid && (heading_due.size() == 0);
    end
  end

  // Stimulus sequence
  initial begin
    // coincident points and the four axis directions
    add_pair(0, 0, 0, 0);
    add_pair(100, 100, 100, 50);
    add_pair(100, 100, 100, 150);
    add_pair(-5, 7, 20, 7);
    add_pair(20, 7, -5, 7);
    // full-range diagonals in every quadrant
    add_pair(-32768, -32768, 32767, 32767);
    add_pair(32767, 32767, -32768, -32768);
    add_pair(-32768, 32767, 32767, -32768);
    add_pair(32767, -32768, -32768, 32767);
    // unit diagonals
    add_pair(0, 0, 1, 1);
    add_pair(0, 0, -1, 1);
    add_pair(0, 0, 1, -1);
    add_pair(0, 0, -1, -1);
    // just off the horizontal, including the wrap to zero
    add_pair(0, 0, 32767, 1);
    add_pair(0, 0, 32767, -1);
    add_pair(0, 0, -32768, 1);
    add_pair(0, 0, -32768, -1);
    // longest axis vectors
    add_pair(-32768, 0, 32767, 0);
    add_pair(32767, 0, -32768, 0);
    add_pair(0, -32768, 0, 32767);
    add_pair(0, 32767, 0, -32768);
    // just off the vertical
    add_pair(0, 0, 1, -32768);
    add_pair(0, 0, -1, 32767);

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    wait_drained();
    add_random_pairs(900);
    // sender pause until every result is back
    wait_drained();
    add_random_pairs(900);
    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);

    if (heading_due.size() != 0)
      report_mismatch($sformatf("%0d predicted results never arrived", heading_due.size()));
    if (mismatch_count == 0) begin
      $display("[heading_angle_256] OK");
    end else begin
      $display("[heading_angle_256] ERROR");
    end
    $finish;
  end

endmodule
